@@ rtl/mtr_pkg.sv @@
// Shared widths, register codes, command/status types and exponential table of the router.
package mtr_pkg;

  localparam int MAX_EXPERTS     = 256;
  localparam int MAX_TOPK        = 8;
  localparam int EXP_TABLE_DEPTH = 1024;

  localparam int CNT_W     = 9;
  localparam int K_W       = 4;
  localparam int LOGIT_W   = 16;
  localparam int ID_W      = 8;
  localparam int WEIGHT_W  = 16;
  localparam int E_W       = 17;
  localparam int CFG_IDX_W = 2;
  localparam int SLOT_W    = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;
  localparam int FILL_W    = $clog2(MAX_TOPK + 1);
  localparam int SUM_W     = $clog2(MAX_TOPK * 65536 + 1);
  localparam int NUM_W     = E_W + WEIGHT_W + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int ROM_AW    = $clog2(EXP_TABLE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_EXPERT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_K        = CFG_IDX_W'(1);

  typedef struct packed {
    logic insert;
    logic exp_rd;
    logic exp_acc;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic round_end;
    logic j_last;
    logic div_done;
  } status_t;

  typedef logic [E_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t   rom;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] s;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      y    = (64'(i) << 30) / 64'(EXP_TABLE_DEPTH);
      term = 64'(1) << 30;
      s    = 64'(1) << 30;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * y) >> 30) / 64'(k);
        if ((k % 2) == 1) begin
          s = s - term;
        end else begin
          s = s + term;
        end
      end
      for (int r = 0; r < 4; r++) begin
        s = (s * s) >> 30;
      end
      rom[i] = E_W'((s + 64'(8192)) >> 14);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

@@ rtl/mtr_ctrl.sv @@
// Sequencer for insertion, exponential pass, weight division and result emission.
module mtr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mtr_pkg::status_t  status,
  output mtr_pkg::cmd_t     cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    IDLE,
    EXP_RD,
    EXP_ACC,
    DIV_INIT,
    DIV,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.insert = 1'b1;
          if (status.round_end) begin
            state_next = EXP_RD;
          end
        end
      end
      EXP_RD: begin
        cmd.exp_rd = 1'b1;
        state_next = EXP_ACC;
      end
      EXP_ACC: begin
        cmd.exp_acc = 1'b1;
        state_next  = status.j_last ? DIV_INIT : EXP_RD;
      end
      DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        cmd.emit   = 1'b1;
        state_next = status.j_last ? IDLE : DIV_INIT;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
    end
  end

endmodule

@@ rtl/mtr_datapath.sv @@
// Top-K list, configuration registers, exponential accumulation and restoring divider.
module mtr_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mtr_pkg::cmd_t                        cmd,
  output mtr_pkg::status_t                     status,
  input  logic                                 wr_en,
  input  logic [mtr_pkg::CFG_IDX_W-1:0]        wr_index,
  input  logic [mtr_pkg::CNT_W-1:0]            wr_data,
  input  logic signed [mtr_pkg::LOGIT_W-1:0]   logit,
  output logic                                 valid,
  output logic [mtr_pkg::ID_W-1:0]             expert_id,
  output logic [mtr_pkg::WEIGHT_W-1:0]         weight,
  output logic                                 last_of_run
);

  localparam int FW = mtr_pkg::FILL_W;
  localparam int SW = mtr_pkg::SUM_W;
  localparam int NW = mtr_pkg::NUM_W;

  logic [mtr_pkg::CNT_W-1:0]          expert_count;
  logic [mtr_pkg::K_W-1:0]            top_k;
  logic [FW-1:0]                      filled;
  logic [mtr_pkg::CNT_W-1:0]          counter;
  logic signed [mtr_pkg::LOGIT_W-1:0] best_logit [mtr_pkg::MAX_TOPK];
  logic [mtr_pkg::ID_W-1:0]           best_id    [mtr_pkg::MAX_TOPK];
  logic [mtr_pkg::E_W-1:0]            e_val      [mtr_pkg::MAX_TOPK];
  logic signed [mtr_pkg::LOGIT_W-1:0] prev_logit [mtr_pkg::MAX_TOPK];
  logic [mtr_pkg::ID_W-1:0]           prev_id    [mtr_pkg::MAX_TOPK];
  logic [FW-1:0]                      n_res;
  logic [mtr_pkg::SLOT_W-1:0]         j;
  logic [SW-1:0]                      sum;
  logic [mtr_pkg::E_W-1:0]            rom_q;
  logic [NW-1:0]                      num;
  logic [NW-1:0]                      quot;
  logic [SW-1:0]                      rem;
  logic [mtr_pkg::DIV_CNT_W-1:0]      div_cnt;

  logic [FW-1:0]                      k_eff;
  logic [mtr_pkg::CNT_W-1:0]          count_eff;
  logic [FW-1:0]                      fill_c;
  logic [mtr_pkg::MAX_TOPK-1:0]       ge;
  logic [FW-1:0]                      p;
  logic                               do_ins;
  logic [FW-1:0]                      fill_ins;
  logic [mtr_pkg::CNT_W-1:0]          counter_inc;
  logic signed [mtr_pkg::LOGIT_W:0]   diff;
  logic [SW:0]                        rem_sh;
  logic                               q_bit;

  function automatic logic [FW-1:0] eff_k(input logic [mtr_pkg::K_W-1:0] kv);
    logic [FW-1:0] r;
    if (kv == '0) begin
      r = FW'(1);
    end else if (32'(kv) > mtr_pkg::MAX_TOPK) begin
      r = FW'(mtr_pkg::MAX_TOPK);
    end else begin
      r = FW'(kv);
    end
    return r;
  endfunction

  always_comb begin
    k_eff = eff_k(top_k);
    if (expert_count < mtr_pkg::CNT_W'(2)) begin
      count_eff = mtr_pkg::CNT_W'(2);
    end else if (32'(expert_count) > mtr_pkg::MAX_EXPERTS) begin
      count_eff = mtr_pkg::CNT_W'(mtr_pkg::MAX_EXPERTS);
    end else begin
      count_eff = expert_count;
    end
    fill_c = (filled > k_eff) ? k_eff : filled;
    for (int i = 0; i < mtr_pkg::MAX_TOPK; i++) begin
      ge[i] = (FW'(i) < fill_c) && (best_logit[i] >= logit);
    end
    prev_logit[0] = logit;
    prev_id[0]    = counter[mtr_pkg::ID_W-1:0];
    for (int i = 1; i < mtr_pkg::MAX_TOPK; i++) begin
      prev_logit[i] = best_logit[i-1];
      prev_id[i]    = best_id[i-1];
    end
    p           = FW'($countones(ge));
    do_ins      = (p < k_eff);
    fill_ins    = (do_ins && (fill_c < k_eff)) ? fill_c + FW'(1) : fill_c;
    counter_inc = counter + mtr_pkg::CNT_W'(1);
    diff        = {best_logit[0][mtr_pkg::LOGIT_W-1], best_logit[0]}
                - {best_logit[j][mtr_pkg::LOGIT_W-1], best_logit[j]};
    rem_sh      = {rem, num[NW-1]};
    q_bit       = (rem_sh >= {1'b0, sum});
  end

  assign status.round_end = (counter_inc >= count_eff);
  assign status.j_last    = ((FW'(j) + FW'(1)) == n_res);
  assign status.div_done  = (div_cnt == mtr_pkg::DIV_CNT_W'(NW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      expert_count <= mtr_pkg::CNT_W'(mtr_pkg::MAX_EXPERTS);
      top_k        <= mtr_pkg::K_W'(mtr_pkg::MAX_TOPK);
      filled       <= '0;
      counter      <= '0;
      valid        <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (cmd.insert) begin
        if (do_ins) begin
          for (int i = 0; i < mtr_pkg::MAX_TOPK; i++) begin
            if (FW'(i) >= p) begin
              best_logit[i] <= (FW'(i) == p) ? logit : prev_logit[i];
              best_id[i]    <= (FW'(i) == p) ? counter[mtr_pkg::ID_W-1:0] : prev_id[i];
            end
          end
        end
        filled  <= fill_ins;
        counter <= counter_inc;
        n_res   <= fill_ins;
        j       <= '0;
        sum     <= '0;
      end
      if (cmd.exp_rd) begin
        rom_q <= (|diff[mtr_pkg::LOGIT_W:12]) ? '0
               : mtr_pkg::EXP_ROM[diff[11:12-mtr_pkg::ROM_AW]];
      end
      if (cmd.exp_acc) begin
        e_val[j] <= rom_q;
        sum      <= sum + SW'(rom_q);
        j        <= status.j_last ? '0 : j + mtr_pkg::SLOT_W'(1);
      end
      if (cmd.div_init) begin
        num     <= NW'({e_val[j], 16'b0}) + NW'(sum[SW-1:1]);
        rem     <= '0;
        quot    <= '0;
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        rem     <= q_bit ? SW'(rem_sh - {1'b0, sum}) : rem_sh[SW-1:0];
        num     <= {num[NW-2:0], 1'b0};
        quot    <= {quot[NW-2:0], q_bit};
        div_cnt <= div_cnt + mtr_pkg::DIV_CNT_W'(1);
      end
      if (cmd.emit) begin
        valid       <= 1'b1;
        expert_id   <= best_id[j];
        weight      <= (|quot[NW-1:mtr_pkg::WEIGHT_W]) ? '1 : quot[mtr_pkg::WEIGHT_W-1:0];
        last_of_run <= status.j_last;
        j           <= j + mtr_pkg::SLOT_W'(1);
        if (status.j_last) begin
          filled  <= '0;
          counter <= '0;
        end
      end
      if (wr_en) begin
        case (wr_index)
          mtr_pkg::REG_EXPERT_COUNT: begin
            expert_count <= wr_data;
          end
          mtr_pkg::REG_TOP_K: begin
            top_k <= wr_data[mtr_pkg::K_W-1:0];
            if (filled > eff_k(wr_data[mtr_pkg::K_W-1:0])) begin
              filled <= eff_k(wr_data[mtr_pkg::K_W-1:0]);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/moe_topk_router_core.sv @@
// Top level of the mixture-of-experts top-K router.
//
// Usage: write expert_count (index 0) and top_k (index 1) through wr_en,
// wr_index, wr_data while the block is idle. Then present one Q8.8 logit
// per item, expert 0 first; an item is taken at a clock edge with start
// high and busy low. Items may follow back to back, as the insertion into
// the sorted top-K list is done in parallel.
// After the logit of the last expert, busy goes high and the block walks
// the N chosen entries (N = min(K, experts seen)): a table read and a sum
// for each in the exponential pass, then for each weight one load, 34 steps
// of the bit-serial divider and one emit. Results come out highest logit
// first, each on expert_id, weight and last_of_run for one cycle with valid
// high; the receiver cannot stall them.
// Busy falls together with the last result.
// Reset clears the list fill, the expert count of the round and sets
// expert_count to 256 and top_k to 8.
module moe_topk_router_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mtr_pkg::LOGIT_W-1:0]   logit,
  input  logic                                 wr_en,
  input  logic [mtr_pkg::CFG_IDX_W-1:0]        wr_index,
  input  logic [mtr_pkg::CNT_W-1:0]            wr_data,
  output logic                                 valid,
  output logic [mtr_pkg::ID_W-1:0]             expert_id,
  output logic [mtr_pkg::WEIGHT_W-1:0]         weight,
  output logic                                 last_of_run
);

  mtr_pkg::cmd_t    cmd;
  mtr_pkg::status_t status;

  mtr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mtr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .logit       (logit),
    .valid       (valid),
    .expert_id   (expert_id),
    .weight      (weight),
    .last_of_run (last_of_run)
  );

endmodule

@@ rtl/mtr_checker.sv @@
// Port-level assertions for the router, bound to the top level.
module mtr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic valid,
  input logic last_of_run
);

  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last_of_run |-> busy)
    else $error("non-final result while not busy");

  a_accept_no_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !valid)
    else $error("result right after an accepted item");

  a_results_spaced: assert property (@(posedge clk) disable iff (rst)
    valid && !last_of_run |=> !valid)
    else $error("results in adjacent cycles");

  a_busy_ends_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> valid && last_of_run)
    else $error("busy fell without the final result");

endmodule

bind moe_topk_router_core mtr_checker u_mtr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .valid       (valid),
  .last_of_run (last_of_run)
);
